// ----- rtl/core/tct_pkg.sv -----
// Package for the temperature-compensated tuning block.
// Item types, register codes, drift table and constant reciprocals.
// No dependencies.
package tct_pkg;

  // Tuning command item
  typedef struct packed {
    logic        [26:0] requested_freq;
    logic signed [15:0] osc_temp;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic        [26:0] applied_freq;
    logic signed [15:0] error_hz;
    logic        [27:0] osc_command;
    logic        [2:0]  band_index;
    logic        [3:0]  filter_lines;
  } out_item_t;

  // Item handed from the front part to the back part
  typedef struct packed {
    logic [26:0] freq;      // clamped frequency, Hz
    logic [9:0]  temp_ofs;  // clamped temperature + 20.0 C, tenths (0..899)
  } mid_item_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_FREQ = 2'd0,
    CFG_MIN_FREQ = 2'd1,
    CFG_INIT_ERR = 2'd2
  } cfg_idx_t;

  localparam logic [26:0]        MAX_FREQ_RST = 27'd54000000;
  localparam logic [26:0]        MIN_FREQ_RST = 27'd100000;
  localparam logic signed [15:0] INIT_ERR_RST = 16'sd21866;

  localparam logic signed [15:0] TEMP_LOW  = -16'sd200;
  localparam logic signed [15:0] TEMP_HIGH = 16'sd699;
  localparam logic [5:0]         TEMP_STEP = 6'd50;

  // floor(t/50) for t < 900: (t * 1311) >> 16
  localparam logic [10:0] STEP_RECIP = 11'd1311;
  // floor(f/10000) = floor((f>>4) * 13743896 >> 33) for f < 2^27
  localparam logic [23:0] FQ_RECIP   = 24'd13743896;
  // floor(a/100) = floor((a>>2) * 83887 >> 21) for a < 2^18
  localparam logic [16:0] INTP_RECIP = 17'd83887;
  // floor(a/100000) = floor((a>>5) * 43980466 >> 37) for a < 2^30
  localparam logic [25:0] ERR_RECIP  = 26'd43980466;

  localparam logic [27:0] CMD_MAX = 28'd268435455;

  localparam int unsigned NUM_BANDS_UPPER = 7;
  localparam logic [26:0] BAND_UPPER [NUM_BANDS_UPPER] = '{
    27'd2690000, 27'd4800000, 27'd7650000, 27'd11000000,
    27'd16100000, 27'd22800000, 27'd31600000
  };

  // Oscillator drift in ppb, one point every 5.0 C from -20 C
  function automatic logic signed [13:0] drift_ppb(input logic [4:0] idx);
    logic signed [13:0] d;
    case (idx)
      5'd0:    d = -14'sd2917;
      5'd1:    d = -14'sd4354;
      5'd2:    d = -14'sd5187;
      5'd3:    d = -14'sd5485;
      5'd4:    d = -14'sd5319;
      5'd5:    d = -14'sd4758;
      5'd6:    d = -14'sd3871;
      5'd7:    d = -14'sd2729;
      5'd8:    d = -14'sd1400;
      5'd9:    d = 14'sd0;
      5'd10:   d = 14'sd1538;
      5'd11:   d = 14'sd3008;
      5'd12:   d = 14'sd4386;
      5'd13:   d = 14'sd5602;
      5'd14:   d = 14'sd6587;
      5'd15:   d = 14'sd7271;
      5'd16:   d = 14'sd7584;
      5'd17:   d = 14'sd7458;
      5'd18:   d = 14'sd6821;
      default: d = 14'sd0;
    endcase
    return d;
  endfunction

  // Filter select lines per band: bit0 S0, bit1 S1, bit2 CS0, bit3 CS1
  function automatic logic [3:0] band_lines(input logic [2:0] band);
    logic [3:0] l;
    case (band)
      3'd0:    l = 4'd11;
      3'd1:    l = 4'd7;
      3'd2:    l = 4'd10;
      3'd3:    l = 4'd6;
      3'd4:    l = 4'd9;
      3'd5:    l = 4'd5;
      3'd6:    l = 4'd8;
      3'd7:    l = 4'd4;
      default: l = 4'd11;
    endcase
    return l;
  endfunction

endpackage

// ----- rtl/core/tct_queue.sv -----
// Small first-in first-out queue of packed items.
// Used between front and back part and as the result queue. Depends on nothing.
module tct_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  T                 entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entry_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- rtl/core/tct_front.sv -----
// Front part: configuration registers, frequency and temperature clamping.
// Depends on tct_pkg.
module tct_front (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [26:0]          cfg_data,
  // command items
  input  tct_pkg::in_item_t    cmd,
  // clamped items toward the queue
  output tct_pkg::mid_item_t   mid,
  // initial error for the back part
  output logic signed [15:0]   init_err
);
  import tct_pkg::*;

  logic [26:0]        max_freq_r;
  logic [26:0]        min_freq_r;
  logic signed [15:0] init_err_r;
  logic signed [15:0] temp_cl;
  logic signed [15:0] temp_sum;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_freq_r <= MAX_FREQ_RST;
      min_freq_r <= MIN_FREQ_RST;
      init_err_r <= INIT_ERR_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_FREQ: max_freq_r <= cfg_data;
        CFG_MIN_FREQ: min_freq_r <= cfg_data;
        CFG_INIT_ERR: init_err_r <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  assign init_err = init_err_r;

  // clamp frequency (upper limit wins) and temperature
  always_comb begin
    if (cmd.requested_freq > max_freq_r) begin
      mid.freq = max_freq_r;
    end else if (cmd.requested_freq < min_freq_r) begin
      mid.freq = min_freq_r;
    end else begin
      mid.freq = cmd.requested_freq;
    end

    if ($signed(cmd.osc_temp) < TEMP_LOW) begin
      temp_cl = TEMP_LOW;
    end else if ($signed(cmd.osc_temp) > TEMP_HIGH) begin
      temp_cl = TEMP_HIGH;
    end else begin
      temp_cl = $signed(cmd.osc_temp);
    end
    temp_sum     = temp_cl - TEMP_LOW;
    mid.temp_ofs = temp_sum[9:0];
  end

endmodule

// ----- rtl/core/tct_back.sv -----
// Back part: interpolation, ppb to Hz scaling, command and band, ten stages.
// Issues from the middle queue on credit from the result queue. Depends on tct_pkg.
module tct_back #(
  parameter int OUT_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tct_pkg::mid_item_t  mid,
  input  logic                mid_empty,
  output logic                mid_pop,
  input  logic signed [15:0]  init_err,
  input  logic                release_credit,
  output logic                res_valid,
  output tct_pkg::out_item_t  res
);
  import tct_pkg::*;

  localparam int NST   = 10;
  localparam int OCC_W = $clog2(OUT_DEPTH + 1);

  logic [NST-1:0]   vld_r;
  logic [OCC_W-1:0] occ_r, occ_nxt;

  // items in flight or waiting in the result queue
  assign mid_pop = !mid_empty && (occ_r < OCC_W'(OUT_DEPTH));

  always_comb begin
    occ_nxt = occ_r;
    if (mid_pop && !release_credit) begin
      occ_nxt = occ_r + 1'b1;
    end else if (release_credit && !mid_pop) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      vld_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      vld_r <= {vld_r[NST-2:0], mid_pop};
    end
  end

  // frequency and band travel alongside
  logic [26:0] freq_r [NST];
  logic [2:0]  band_r [NST];

  // stage payloads
  logic [9:0]         s1_t_r, s2_t_r;
  logic [4:0]         s2_idx_r;
  logic [13:0]        s2_fq_r, s3_fq_r, s4_fq_r, s5_fq_r, s6_fq_r, s7_fq_r;
  logic signed [13:0] s3_slope_r;
  logic [5:0]         s3_off_r;
  logic signed [13:0] s3_base_r, s4_base_r, s5_base_r, s6_base_r;
  logic signed [20:0] s4_prod_r;
  logic               s5_neg_r, s6_neg_r;
  logic [17:0]        s5_mag_r;
  logic [11:0]        s6_qm_r;
  logic signed [17:0] s7_ppb_r;
  logic signed [32:0] s8_total_r;
  logic               s9_neg_r, s10_neg_r;
  logic [29:0]        s9_mag_r;
  logic [13:0]        s10_q_r;

  // stage 1 comb: step index, frequency in 10 kHz units, band
  logic [20:0] idx_prod;
  logic [46:0] fq_prod;
  logic [2:0]  band_cnt;
  always_comb begin
    idx_prod = 21'(s1_t_r) * 21'(STEP_RECIP);
    fq_prod  = 47'(freq_r[0][26:4]) * 47'(FQ_RECIP);
    band_cnt = '0;
    for (int i = 0; i < NUM_BANDS_UPPER; i++) begin
      band_cnt = band_cnt + 3'(freq_r[0] > BAND_UPPER[i]);
    end
  end

  // stage 2 comb: table lookup, slope, offset in step
  logic signed [13:0] base_v, next_v, diff_v;
  logic [9:0]         off_full;
  always_comb begin
    base_v   = drift_ppb(s2_idx_r);
    next_v   = drift_ppb(s2_idx_r + 5'd1);
    diff_v   = next_v - base_v;
    off_full = s2_t_r - 10'(s2_idx_r * 10'(TEMP_STEP));
  end

  // stage 3 comb: slope times offset
  logic signed [20:0] slope_x, off_x, prod_v;
  always_comb begin
    slope_x = 21'(s3_slope_r);
    off_x   = $signed({15'b0, s3_off_r});
    prod_v  = slope_x * off_x;
  end

  // stage 4 comb: magnitude for truncating division
  logic signed [20:0] prod_abs;
  assign prod_abs = s4_prod_r[20] ? -s4_prod_r : s4_prod_r;

  // stage 5 comb: divide by 100
  logic [32:0] qm_prod;
  assign qm_prod = 33'(s5_mag_r[17:2]) * 33'(INTP_RECIP);

  // stage 6 comb: restore sign, add table point and initial error
  logic signed [12:0] interp_v;
  logic signed [17:0] ppb_v;
  always_comb begin
    interp_v = s6_neg_r ? -$signed({1'b0, s6_qm_r}) : $signed({1'b0, s6_qm_r});
    ppb_v    = 18'(interp_v) + 18'(s6_base_r) + 18'(init_err);
  end

  // stage 7 comb: ppb times frequency
  logic signed [32:0] total_v, fq_x;
  always_comb begin
    fq_x    = $signed({19'b0, s7_fq_r});
    total_v = 33'(s7_ppb_r) * fq_x;
  end

  // stage 8 comb: magnitude
  logic signed [32:0] total_abs;
  assign total_abs = s8_total_r[32] ? -s8_total_r : s8_total_r;

  // stage 9 comb: divide by 100000
  logic [50:0] q_prod;
  assign q_prod = 51'(s9_mag_r[29:5]) * 51'(ERR_RECIP);

  // stage 10 comb: correction, saturated command, filter lines
  logic signed [15:0] err_v;
  logic signed [28:0] sum_v;
  always_comb begin
    err_v = s10_neg_r ? -$signed({2'b0, s10_q_r}) : $signed({2'b0, s10_q_r});
    sum_v = $signed({2'b0, freq_r[NST-1]}) + 29'(err_v);
    res.applied_freq = freq_r[NST-1];
    res.error_hz     = err_v;
    if (sum_v[28]) begin
      res.osc_command = '0;
    end else if (sum_v[27]) begin
      res.osc_command = CMD_MAX;
    end else begin
      res.osc_command = {sum_v[26:0], 1'b0};
    end
    res.band_index   = band_r[NST-1];
    res.filter_lines = band_lines(band_r[NST-1]);
  end

  assign res_valid = vld_r[NST-1];

  // pipeline registers, no stall
  always_ff @(posedge clk) begin
    freq_r[0] <= mid.freq;
    s1_t_r    <= mid.temp_ofs;
    band_r[0] <= '0;
    for (int k = 1; k < NST; k++) begin
      freq_r[k] <= freq_r[k-1];
      band_r[k] <= (k == 1) ? band_cnt : band_r[k-1];
    end

    s2_t_r   <= s1_t_r;
    s2_idx_r <= idx_prod[20:16];
    s2_fq_r  <= fq_prod[46:33];

    s3_fq_r    <= s2_fq_r;
    s3_slope_r <= {diff_v[12:0], 1'b0};
    s3_off_r   <= off_full[5:0];
    s3_base_r  <= base_v;

    s4_fq_r   <= s3_fq_r;
    s4_base_r <= s3_base_r;
    s4_prod_r <= prod_v;

    s5_fq_r   <= s4_fq_r;
    s5_base_r <= s4_base_r;
    s5_neg_r  <= s4_prod_r[20];
    s5_mag_r  <= prod_abs[17:0];

    s6_fq_r   <= s5_fq_r;
    s6_base_r <= s5_base_r;
    s6_neg_r  <= s5_neg_r;
    s6_qm_r   <= qm_prod[32:21];

    s7_fq_r  <= s6_fq_r;
    s7_ppb_r <= ppb_v;

    s8_total_r <= total_v;

    s9_neg_r <= s8_total_r[32];
    s9_mag_r <= total_abs[29:0];

    s10_neg_r <= s9_neg_r;
    s10_q_r   <= q_prod[50:37];
  end

endmodule

// ----- rtl/core/temp_compensated_tuning.sv -----
// Top level of the temperature-compensated tuning block.
// Depends on tct_pkg, tct_front, tct_queue and tct_back.
//
//  channel   ports                         handshake
//  command   push, full, in_data           taken when push && !full
//  result    empty, pop, out_data          taken when pop && !empty
//  config    cfg_we, cfg_index, cfg_data   written when cfg_we
//
// One command is taken per cycle while full is low; after the edge that takes it, its
// result passes through the ten back-end stages, then the result queue write.
// Throughput is one item per cycle while the result side pops; the back end
// issues only while the result queue has room for everything in flight.
// Reset is synchronous, active low, and restores the configuration defaults.
// A stalled result side fills the result queue, then the middle queue, then full rises.
module temp_compensated_tuning #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  tct_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output tct_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [26:0]        cfg_data
);
  import tct_pkg::*;

  mid_item_t          mid_in, mid_out;
  logic               mid_empty, mid_pop;
  logic signed [15:0] init_err;
  logic               res_valid;
  out_item_t          res;
  logic               out_full;
  logic               release_credit;

  tct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (in_data),
    .mid       (mid_in),
    .init_err  (init_err)
  );

  tct_queue #(.T(mid_item_t), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (mid_in),
    .full  (full),
    .pop   (mid_pop),
    .dout  (mid_out),
    .empty (mid_empty)
  );

  tct_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .mid            (mid_out),
    .mid_empty      (mid_empty),
    .mid_pop        (mid_pop),
    .init_err       (init_err),
    .release_credit (release_credit),
    .res_valid      (res_valid),
    .res            (res)
  );

  // credits guarantee room, so the result queue never sees a push while full
  tct_queue #(.T(out_item_t), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid && !out_full),
    .din   (res),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_data),
    .empty (empty)
  );

  assign release_credit = pop && !empty;

endmodule

// ----- tb/sv/temp_compensated_tuning_tb.sv -----
`timescale 1ns / 100ps
// Testbench for temp_compensated_tuning: table-driven and random tuning commands,
// each result checked field by field against a fixed result or a behavioral predictor.
// Depends on tct_pkg and the temp_compensated_tuning RTL.
module temp_compensated_tuning_tb;
  import tct_pkg::*;

  typedef enum {ROW_CMD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    cfg_idx_t           reg_idx;
    logic [26:0]        value;   // requested frequency or register data
    logic signed [15:0] temp;
    bit                 typed;   // expected result given in the row
    out_item_t          want;
  } plan_row_t;

  // Crystal drift in ppb every 5.0 C from -20 C, and filter lines per band
  localparam int DRIFT_TBL [19] = '{
    -2917, -4354, -5187, -5485, -5319, -4758, -3871, -2729, -1400, 0,
    1538, 3008, 4386, 5602, 6587, 7271, 7584, 7458, 6821
  };
  localparam logic [3:0] SEL_LINES [8] = '{4'd11, 4'd7, 4'd10, 4'd6, 4'd9, 4'd5, 4'd8, 4'd4};
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE      = 16;
  localparam int PHASE_ITEMS = 250;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_data;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [26:0] cfg_data;

  // Register copies used by the predictor
  logic [26:0]        max_hz;
  logic [26:0]        min_hz;
  logic signed [15:0] init_ppb;

  out_item_t pending_tunings [$];
  int sender_idle_pct;
  int receiver_idle_pct;
  bit hold_req;
  bit hold_ack;
  int hold_left;
  int fail_count;
  int cmds_sent;
  int results_seen;
  int typed_seen;
  int stall_cycles;

  temp_compensated_tuning DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Expected result of one tuning command under the current register copies
  function automatic out_item_t tune_result(input in_item_t c);
    out_item_t r;
    longint f, t, seg, base, slope, ppb, corr, e16, cmd;
    int b;
    f = c.requested_freq;
    if (f > max_hz) f = max_hz;
    else if (f < min_hz) f = min_hz;
    t = $signed(c.osc_temp);
    if (t < -200) t = -200;
    else if (t > 699) t = 699;
    // linear interpolation inside the 5 C segment, truncating
    seg   = (t + 200) / 50;
    base  = DRIFT_TBL[seg];
    slope = (DRIFT_TBL[seg + 1] - base) * 2;
    ppb   = slope * (t - (seg * 50 - 200)) / 100 + base + longint'(init_ppb);
    corr  = ppb * (f / 10000) / 100000;
    r.applied_freq = f[26:0];
    r.error_hz     = corr[15:0];
    e16 = $signed(r.error_hz);
    cmd = (e16 + f) * 2;
    if (cmd < 0) cmd = 0;
    else if (cmd > longint'(CMD_MAX)) cmd = CMD_MAX;
    r.osc_command = cmd[27:0];
    b = 0;
    while (b < 7 && f > BAND_UPPER[b]) b++;
    r.band_index   = b[2:0];
    r.filter_lines = SEL_LINES[b];
    return r;
  endfunction

  function automatic plan_row_t cmd_row(input logic [26:0] f, input logic signed [15:0] t);
    plan_row_t r;
    r.kind    = ROW_CMD;
    r.reg_idx = CFG_MAX_FREQ;
    r.value   = f;
    r.temp    = t;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic [26:0] f, input logic signed [15:0] t,
                                          input out_item_t want);
    plan_row_t r;
    r = cmd_row(f, t);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input cfg_idx_t idx, input logic [26:0] data);
    plan_row_t r;
    r = cmd_row(data, '0);
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    return r;
  endfunction

  // Offer one command, wait for it to be taken, record its expected result
  task automatic send_cmd(input in_item_t c, input bit typed, input out_item_t want);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push    = 1'b1;
    in_data = c;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_tunings.push_back(typed ? want : tune_result(c));
    cmds_sent++;
    if (typed) typed_seen++;
    @(negedge clk);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain();
    push = 1'b0;
    while (pending_tunings.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [26:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      CFG_MAX_FREQ: max_hz = data;
      CFG_MIN_FREQ: min_hz = data;
      CFG_INIT_ERR: init_ppb = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Receiver: random pop, plus a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      pop = 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
      pop = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop = 1'b0;
    end else begin
      pop = ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && full) stall_cycles++;
    if (rst_n && pop && !empty) begin
      if (pending_tunings.size() == 0) begin
        $error("result with no command pending: %h", out_data);
        fail_count++;
      end else begin
        exp_r = pending_tunings.pop_front();
        results_seen++;
        if (out_data.applied_freq !== exp_r.applied_freq) begin
          $error("applied_freq: expected %0d, got %0d", exp_r.applied_freq,
                 out_data.applied_freq);
          fail_count++;
        end
        if (out_data.error_hz !== exp_r.error_hz) begin
          $error("error_hz: expected %0d, got %0d", $signed(exp_r.error_hz),
                 $signed(out_data.error_hz));
          fail_count++;
        end
        if (out_data.osc_command !== exp_r.osc_command) begin
          $error("osc_command: expected %0d, got %0d", exp_r.osc_command,
                 out_data.osc_command);
          fail_count++;
        end
        if (out_data.band_index !== exp_r.band_index) begin
          $error("band_index: expected %0d, got %0d", exp_r.band_index, out_data.band_index);
          fail_count++;
        end
        if (out_data.filter_lines !== exp_r.filter_lines) begin
          $error("filter_lines: expected %0d, got %0d", exp_r.filter_lines,
                 out_data.filter_lines);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5000000;
    $display("temp_compensated_tuning_tb: errors");
    $finish;
  end

  // Stimulus
  initial begin
    plan_row_t   plan [$];
    in_item_t    c;
    logic [31:0] rnd;
    int          sel;
    int          edge_hz;
    rst_n = 1'b0;
    push = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_FREQ;
    cfg_data = '0;
    cmds_sent = 0;
    typed_seen = 0;
    max_hz = MAX_FREQ_RST;
    min_hz = MIN_FREQ_RST;
    init_ppb = INIT_ERR_RST;
    sender_idle_pct = 19;
    receiver_idle_pct = 85;

    // Directed table: reset limits, clamps, band edges, temperature ends, saturation
    plan.push_back(typed_row(27'd0, 16'sd0, {27'd100000, 16'sd1, 28'd200002, 3'd0, 4'd11}));
    plan.push_back(typed_row(27'h7FFFFFF, 16'sd0,
                             {27'd54000000, 16'sd893, 28'd108001786, 3'd7, 4'd4}));
    plan.push_back(typed_row(27'd10000000, -16'sd200,
                             {27'd10000000, 16'sd189, 28'd20000378, 3'd3, 4'd6}));
    plan.push_back(typed_row(27'd10000000, 16'sh8000,
                             {27'd10000000, 16'sd189, 28'd20000378, 3'd3, 4'd6}));
    plan.push_back(typed_row(27'd10000000, 16'sh7FFF,
                             {27'd10000000, 16'sd287, 28'd20000574, 3'd3, 4'd6}));
    plan.push_back(cmd_row(27'd10000000, 16'sd699));
    plan.push_back(cmd_row(27'd2690000, -16'sd201));
    plan.push_back(cmd_row(27'd2690001, 16'sd700));
    plan.push_back(cmd_row(27'd4800001, -16'sd1));
    plan.push_back(cmd_row(27'd7650001, 16'sd1));
    plan.push_back(cmd_row(27'd11000001, 16'sd249));
    plan.push_back(cmd_row(27'd16100001, 16'sd250));
    plan.push_back(cmd_row(27'd22800001, 16'sd451));
    plan.push_back(cmd_row(27'd31600000, 16'sd500));
    plan.push_back(cmd_row(27'd31600001, 16'sd123));
    plan.push_back(cmd_row(27'd100000000, -16'sd150));
    plan.push_back(cfg_row(CFG_MIN_FREQ, 27'd0));
    plan.push_back(cfg_row(CFG_MAX_FREQ, 27'h7FFFFFF));
    plan.push_back(cfg_row(CFG_INIT_ERR, 27'h0008000));
    plan.push_back(typed_row(27'd0, 16'sd0, {27'd0, 16'sd0, 28'd0, 3'd0, 4'd11}));
    plan.push_back(typed_row(27'd9999, 16'sd300, {27'd9999, 16'sd0, 28'd19998, 3'd0, 4'd11}));
    plan.push_back(cmd_row(27'h7FFFFFF, -16'sd199));
    plan.push_back(cfg_row(CFG_INIT_ERR, 27'h0007FFF));
    plan.push_back(cmd_row(27'h7FFFFFF, 16'sd0));
    // lower limit above upper limit: upper clamp wins
    plan.push_back(cfg_row(CFG_MIN_FREQ, 27'd100000000));
    plan.push_back(cfg_row(CFG_MAX_FREQ, 27'd50000000));
    plan.push_back(cmd_row(27'd60000000, 16'sd400));
    plan.push_back(cmd_row(27'd1000, 16'sd400));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        c.requested_freq = plan[i].value;
        c.osc_temp       = plan[i].temp;
        send_cmd(c, plan[i].typed, plan[i].want);
      end
    end
    drain();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < 6; phase++) begin
      sender_idle_pct   = (phase < 2) ? 19 : (phase < 4) ? 85 : 0;
      receiver_idle_pct = (phase < 2) ? 85 : (phase < 4) ? 19 : 0;
      rnd = $urandom;
      case (phase)
        0: begin
          write_reg(CFG_MAX_FREQ, 27'd100000000);
          write_reg(CFG_MIN_FREQ, 27'd0);
          write_reg(CFG_INIT_ERR, {11'd0, rnd[15:0]});
        end
        1: begin
          write_reg(CFG_MAX_FREQ, 27'($urandom_range(0, 100000000)));
          write_reg(CFG_MIN_FREQ, 27'($urandom_range(0, 100000000)));
          write_reg(CFG_INIT_ERR, 27'h0007FFF);
        end
        2: begin
          write_reg(CFG_MAX_FREQ, 27'h7FFFFFF);
          write_reg(CFG_MIN_FREQ, 27'd0);
          write_reg(CFG_INIT_ERR, 27'h0008000);
        end
        3: begin
          write_reg(CFG_MAX_FREQ, rnd[26:0]);
          write_reg(CFG_MIN_FREQ, 27'($urandom_range(0, 20000000)));
          write_reg(CFG_INIT_ERR, {11'd0, rnd[31:16]});
        end
        4: begin
          write_reg(CFG_MAX_FREQ, MAX_FREQ_RST);
          write_reg(CFG_MIN_FREQ, MIN_FREQ_RST);
          write_reg(CFG_INIT_ERR, {11'd0, INIT_ERR_RST});
          // receiver holds off long enough to back the block up to full
          hold_req = ~hold_req;
        end
        default: begin
          write_reg(CFG_MAX_FREQ, 27'($urandom_range(1000000, 60000000)));
          write_reg(CFG_MIN_FREQ, 27'($urandom_range(0, 5000000)));
          write_reg(CFG_INIT_ERR, {11'd0, rnd[15:0]});
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // frequency: mostly in range, some band edges, low values, any 27-bit value
        sel = $urandom_range(0, 99);
        rnd = $urandom;
        if (sel < 60) begin
          c.requested_freq = 27'($urandom_range(0, 100000000));
        end else if (sel < 75) begin
          edge_hz = BAND_UPPER[$urandom_range(0, 6)] + $urandom_range(0, 2) - 1;
          c.requested_freq = edge_hz[26:0];
        end else if (sel < 85) begin
          c.requested_freq = 27'($urandom_range(0, 20000));
        end else begin
          c.requested_freq = rnd[26:0];
        end
        // temperature: mostly in table range, some at the clamp points, any 16-bit value
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          edge_hz = $urandom_range(0, 899);
          c.osc_temp = 16'(edge_hz - 200);
        end else if (sel < 80) begin
          edge_hz = $urandom_range(0, 2);
          c.osc_temp = ($urandom_range(0, 1) != 0) ? 16'(edge_hz - 201) :
                                                     16'(edge_hz + 698);
        end else begin
          c.osc_temp = rnd[31:16];
        end
        send_cmd(c, 1'b0, '0);
        // sender waits mid-phase until all results are back
        if (phase == 2 && n == PHASE_ITEMS / 2) drain();
      end
      drain();
    end

    repeat (30) @(posedge clk);
    if (pending_tunings.size() != 0) begin
      $error("%0d results never arrived", pending_tunings.size());
    end
    $display("Covered %0d tuning commands (%0d with fixed expectations), %0d results checked,",
             cmds_sent, typed_seen, results_seen);
    $display("register limits at extremes and crossed, full asserted for %0d cycles.",
             stall_cycles);
    if (fail_count == 0 && pending_tunings.size() == 0) begin
      $display("temp_compensated_tuning_tb: clean");
    end else begin
      $display("temp_compensated_tuning_tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/tct_pkg.sv
rtl/core/tct_queue.sv
rtl/core/tct_front.sv
rtl/core/tct_back.sv
rtl/core/temp_compensated_tuning.sv
tb/sv/temp_compensated_tuning_tb.sv
